FILE: rtl/fdrt_pkg.sv
// ----------------------------------------------------------------------------
// fdrt_pkg: shared types and constants of the frame duration run table
// Word layouts of both channels, the run entry, the divider handshake and
// the sequencer states.
// ----------------------------------------------------------------------------
package fdrt_pkg;

	localparam int MAX_RUNS = 1024;
	localparam int RUN_AW   = $clog2(MAX_RUNS);
	localparam int CNT_W    = RUN_AW + 1;

	localparam logic [47:0] MAX48   = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] MAX_CNT = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_F2T    = 2'd1,
		OP_T2F    = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [31:0]        entry_duration;
		logic signed [47:0] query_value;
	} req_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [47:0] answer_value;
		logic [31:0]        found_duration;
		logic signed [47:0] frame_start;
		logic [47:0]        frames_total;
		logic [47:0]        duration_total;
	} rsp_word_t;

	typedef struct packed {
		logic [31:0] cnt;
		logic [31:0] dur;
	} run_t;

	typedef struct packed {
		logic        start;
		logic [47:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [47:0] quot;
		logic [31:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APP_RD,
		S_APP_EV,
		S_WALK,
		S_F2T_MUL,
		S_F2T_ADD,
		S_DIV_GO,
		S_DIV_WAIT,
		S_DONE
	} state_t;

endpackage

FILE: rtl/fdrt_run_mem.sv
// ----------------------------------------------------------------------------
// fdrt_run_mem: run storage
// One write port and one registered read port, one entry per run.
// ----------------------------------------------------------------------------
module fdrt_run_mem (
	input  logic                        clk,
	input  logic                        wen,
	input  logic [fdrt_pkg::RUN_AW-1:0] waddr,
	input  fdrt_pkg::run_t              wdata,
	input  logic [fdrt_pkg::RUN_AW-1:0] raddr,
	output fdrt_pkg::run_t              rdata
);
	import fdrt_pkg::*;

	run_t mem [MAX_RUNS];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/fdrt_div.sv
// ----------------------------------------------------------------------------
// fdrt_div: restoring divider
// 48-bit dividend by 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdrt_div (
	input  logic               clk,
	input  logic               arst_n,
	input  fdrt_pkg::div_req_t req,
	output fdrt_pkg::div_rsp_t rsp
);
	import fdrt_pkg::*;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] dsr_q;
	logic        done_q;
	logic [32:0] trial;
	logic        bit_ok;

	assign trial  = {rem_q, quo_q[47]};
	assign bit_ok = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= bit_ok ? 32'(trial - {1'b0, dsr_q}) : trial[31:0];
			quo_q <= {quo_q[46:0], bit_ok};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: rtl/frame_duration_run_table.sv
// ----------------------------------------------------------------------------
// frame_duration_run_table: run-length table of frame durations
// Appends frame durations as runs, maps frames to times and back, and clears.
// ----------------------------------------------------------------------------
// Usage notes.
// A request word arrives on req (valid/ready) and carries an operation: append
// a duration, frame to time, time to frame, or clear. Exactly one response word
// leaves on rsp (valid/ready) for each request, in order. cfg_wen writes the
// time offset of the first frame; it should only be written while the block
// is idle.
// The block works on one word at a time. An append reads the last run,
// extends it when the duration matches or else, if there is room, opens
// a new one, and then responds; a clear responds directly. Lookups walk
// the run memory one entry per cycle through a registered read and a
// multiplier stage until they hit; frame to time then scales the hit run
// and time to frame splits it in the bit-serial divider. The single read
// port of the run memory sets the walking speed.
// Reset clears the run count, both totals and the offset; the run memory is
// not cleared since only entries below the run count are ever used.
// The response sits in an output register, so a new request is taken while
// the previous response still waits; a stalled receiver only holds the block
// once the next response is ready to be written.
// ----------------------------------------------------------------------------
module frame_duration_run_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  fdrt_pkg::req_word_t req_word,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output fdrt_pkg::rsp_word_t rsp_word,
	input  logic                cfg_wen,
	input  logic signed [47:0]  cfg_wdata
);
	import fdrt_pkg::*;

	state_t state_q, state_d;

	// Request held for the whole operation.
	logic [1:0]         op_q;
	logic [31:0]        dur_q;
	logic signed [47:0] qry_q;

	// Architectural state kept in flops.
	logic [CNT_W-1:0]   runs_used_q;
	logic [47:0]        frame_sum_q;
	logic [47:0]        time_sum_q;
	logic signed [47:0] time_offset_q;

	// Walk pipeline.
	logic [CNT_W-1:0]   idx_q;
	logic               rv_s1;
	logic               v_s2;
	logic [63:0]        prod_s2;
	logic [31:0]        c_s2;
	logic [31:0]        d_s2;
	logic [47:0]        f_q;
	logic [47:0]        acc_q;
	logic [47:0]        rel_q;
	logic [47:0]        frames_q;
	logic [31:0]        hit_f_q;
	logic [31:0]        hit_d_q;
	logic [63:0]        hprod_q;

	// Result fields being built.
	logic [1:0]         status_q;
	logic [47:0]        answer_q;
	logic [31:0]        fdur_q;
	logic [47:0]        fstart_q;

	rsp_word_t          rsp_q;
	logic               rsp_valid_q;

	// Memory ports.
	logic               mem_wen;
	logic [RUN_AW-1:0]  mem_waddr;
	run_t               mem_wdata;
	logic [RUN_AW-1:0]  mem_raddr;
	run_t               mem_rdata;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic               accept;
	logic               issue;
	logic               f2t_hit;
	logic               t2f_hit;
	logic               app_match;
	logic [RUN_AW-1:0]  last_idx;
	logic [48:0]        tsum_add;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	assign last_idx  = RUN_AW'(runs_used_q - CNT_W'(1));
	assign issue     = (state_q == S_WALK) && (idx_q < runs_used_q);
	assign f2t_hit   = rv_s1 && (f_q < 48'(mem_rdata.cnt));
	assign t2f_hit   = v_s2 && (op_q == OP_T2F) && ({16'b0, rel_q} < prod_s2);
	assign app_match = (runs_used_q != '0) && (mem_rdata.dur == dur_q)
		&& (mem_rdata.cnt != MAX_CNT);
	assign tsum_add  = {1'b0, time_sum_q} + 49'(dur_q);

	assign mem_raddr = (state_q == S_WALK) ? idx_q[RUN_AW-1:0] : last_idx;

	fdrt_run_mem u_mem (
		.clk   (clk),
		.wen   (mem_wen),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign div_req.start    = (state_q == S_DIV_GO);
	assign div_req.dividend = rel_q;
	assign div_req.divisor  = hit_d_q;

	fdrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Next state and memory write.
	always_comb begin
		state_d   = state_q;
		mem_wen   = 1'b0;
		mem_waddr = runs_used_q[RUN_AW-1:0];
		mem_wdata = '{cnt: 32'd1, dur: dur_q};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op_t'(req_word.operation))
						OP_APPEND: state_d = S_APP_RD;
						OP_F2T: state_d = req_word.query_value[47] ? S_DONE : S_WALK;
						OP_T2F: state_d = (req_word.query_value < time_offset_q)
							? S_DONE : S_WALK;
						OP_CLEAR: state_d = S_DONE;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_APP_RD: state_d = S_APP_EV;
			S_APP_EV: begin
				state_d = S_DONE;
				if (app_match) begin
					mem_wen   = 1'b1;
					mem_waddr = last_idx;
					mem_wdata = '{cnt: mem_rdata.cnt + 32'd1, dur: dur_q};
				end else if (runs_used_q < CNT_W'(MAX_RUNS)) begin
					mem_wen = 1'b1;
				end
			end
			S_WALK: begin
				if (op_q == OP_F2T) begin
					if (f2t_hit) begin
						state_d = S_F2T_MUL;
					end else if (!rv_s1 && !issue) begin
						state_d = S_DONE;
					end
				end else begin
					if (t2f_hit) begin
						state_d = S_DIV_GO;
					end else if (!v_s2 && !rv_s1 && !issue) begin
						state_d = S_DONE;
					end
				end
			end
			S_F2T_MUL: state_d = S_F2T_ADD;
			S_F2T_ADD: state_d = S_DONE;
			S_DIV_GO: state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			runs_used_q   <= '0;
			frame_sum_q   <= '0;
			time_sum_q    <= '0;
			time_offset_q <= '0;
			rsp_valid_q   <= 1'b0;
			rv_s1         <= 1'b0;
			v_s2          <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				time_offset_q <= cfg_wdata;
			end
			rv_s1 <= issue;
			v_s2  <= (state_q == S_WALK) && rv_s1
				&& !(op_q == OP_F2T && f2t_hit) && !t2f_hit;
			if (state_q == S_IDLE && accept && req_word.operation == OP_CLEAR) begin
				runs_used_q <= '0;
				frame_sum_q <= '0;
				time_sum_q  <= '0;
			end
			if (state_q == S_APP_EV
				&& (app_match || runs_used_q < CNT_W'(MAX_RUNS))) begin
				if (!app_match) begin
					runs_used_q <= runs_used_q + CNT_W'(1);
				end
				frame_sum_q <= (frame_sum_q == MAX48) ? MAX48 : frame_sum_q + 48'd1;
				time_sum_q  <= tsum_add[48] ? MAX48 : tsum_add[47:0];
			end
			// A new response may be loaded in the cycle the old one leaves.
			if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			op_q     <= req_word.operation;
			dur_q    <= req_word.entry_duration;
			qry_q    <= req_word.query_value;
			idx_q    <= '0;
			f_q      <= req_word.query_value;
			acc_q    <= time_offset_q;
			rel_q    <= 48'(req_word.query_value - time_offset_q);
			frames_q <= '0;
			answer_q <= '0;
			fdur_q   <= '0;
			fstart_q <= '0;
			unique case (op_t'(req_word.operation))
				OP_F2T, OP_T2F: status_q <= ST_NOT_FOUND;
				OP_APPEND, OP_CLEAR: status_q <= ST_OK;
				default: status_q <= ST_OK;
			endcase
		end
		if (state_q == S_APP_EV && !app_match && runs_used_q >= CNT_W'(MAX_RUNS)) begin
			status_q <= ST_FULL;
		end
		if (issue) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		// Products of passed runs join the running time from the product register.
		if (v_s2 && op_q == OP_F2T) begin
			acc_q <= acc_q + prod_s2[47:0];
		end
		if (rv_s1) begin
			prod_s2 <= mem_rdata.cnt * mem_rdata.dur;
			c_s2    <= mem_rdata.cnt;
			d_s2    <= mem_rdata.dur;
		end
		if (state_q == S_WALK && op_q == OP_F2T && rv_s1) begin
			if (f2t_hit) begin
				hit_f_q <= f_q[31:0];
				hit_d_q <= mem_rdata.dur;
			end else begin
				f_q <= f_q - 48'(mem_rdata.cnt);
			end
		end
		if (state_q == S_WALK && op_q == OP_T2F && v_s2) begin
			if (t2f_hit) begin
				hit_d_q <= d_s2;
			end else begin
				rel_q    <= rel_q - prod_s2[47:0];
				frames_q <= frames_q + 48'(c_s2);
			end
		end
		if (state_q == S_F2T_MUL) begin
			hprod_q <= hit_f_q * hit_d_q;
		end
		if (state_q == S_F2T_ADD) begin
			answer_q <= acc_q + hprod_q[47:0];
			fdur_q   <= hit_d_q;
			status_q <= ST_OK;
		end
		if (state_q == S_DIV_WAIT && div_rsp.done) begin
			answer_q <= frames_q + div_rsp.quot;
			fstart_q <= 48'(qry_q) - 48'(div_rsp.rem);
			status_q <= ST_OK;
		end
		if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.status         <= status_q;
			rsp_q.answer_value   <= answer_q;
			rsp_q.found_duration <= fdur_q;
			rsp_q.frame_start    <= fstart_q;
			rsp_q.frames_total   <= frame_sum_q;
			rsp_q.duration_total <= time_sum_q;
		end
	end

	// The run count never passes the memory depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		runs_used_q <= CNT_W'(MAX_RUNS))
		else $error("run count beyond table depth");

	// Every open run holds at least one frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		frame_sum_q >= 48'(runs_used_q))
		else $error("frame total below run count");

	// A clear empties the table at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_word.operation == OP_CLEAR) |=> (runs_used_q == '0))
		else $error("clear left runs in the table");

	// The divider only reports back while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV_WAIT))
		else $error("divider result outside its wait state");

endmodule

FILE: dv/fdrt_checker.sv
// ----------------------------------------------------------------------------
// fdrt_checker: response checker for the frame duration run table
// Watches both channels, keeps a shadow of the run table and compares every
// response word with the word expected for the request that caused it.
// ----------------------------------------------------------------------------
module fdrt_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  fdrt_pkg::req_word_t req_word,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  fdrt_pkg::rsp_word_t rsp_word,
	input  logic                cfg_wen,
	input  logic signed [47:0]  cfg_wdata,
	output int                  fail_count,
	output int                  pending
);
	import fdrt_pkg::*;

	localparam logic [47:0] SIGN48 = 48'h8000_0000_0000;

	logic [31:0] tbl_dur [MAX_RUNS];
	logic [31:0] tbl_cnt [MAX_RUNS];
	int          tbl_used;
	logic [47:0] sum_frames;
	logic [47:0] sum_time;
	logic [47:0] offset;
	rsp_word_t   awaited [$];

	assign pending = awaited.size();

	function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? MAX48 : s[47:0];
	endfunction

	// Applies one request to the shadow table and returns the response word.
	function automatic rsp_word_t apply_request(req_word_t rq);
		rsp_word_t   r;
		logic [63:0] f, acc, rel, frames, span, c, d;
		logic [31:0] dur;
		logic [47:0] q;
		int          last;
		r   = '0;
		dur = rq.entry_duration;
		q   = rq.query_value;
		case (op_t'(rq.operation))
			OP_APPEND: begin
				last = tbl_used - 1;
				if (tbl_used > 0 && tbl_dur[last] == dur && tbl_cnt[last] != MAX_CNT) begin
					tbl_cnt[last]++;
					sum_frames = add_sat(sum_frames, 48'd1);
					sum_time   = add_sat(sum_time, {16'd0, dur});
				end else if (tbl_used >= MAX_RUNS) begin
					r.status = ST_FULL;
				end else begin
					tbl_dur[tbl_used] = dur;
					tbl_cnt[tbl_used] = 1;
					tbl_used++;
					sum_frames = add_sat(sum_frames, 48'd1);
					sum_time   = add_sat(sum_time, {16'd0, dur});
				end
			end
			OP_F2T: begin
				r.status = ST_NOT_FOUND;
				if (!q[47]) begin
					f   = {16'd0, q};
					acc = {16'd0, offset};
					for (int i = 0; i < tbl_used; i++) begin
						c = tbl_cnt[i];
						d = tbl_dur[i];
						if (f < c) begin
							r.answer_value   = 48'(acc + f * d);
							r.found_duration = d[31:0];
							r.status         = ST_OK;
							break;
						end
						f   -= c;
						acc += c * d;
					end
				end
			end
			OP_T2F: begin
				r.status = ST_NOT_FOUND;
				if ((q ^ SIGN48) >= (offset ^ SIGN48)) begin
					rel    = {16'd0, 48'(q - offset)};
					frames = 0;
					for (int i = 0; i < tbl_used; i++) begin
						c    = tbl_cnt[i];
						d    = tbl_dur[i];
						span = c * d;
						if (rel < span) begin
							r.answer_value = 48'(frames + rel / d);
							r.frame_start  = 48'({16'd0, q} - rel % d);
							r.status       = ST_OK;
							break;
						end
						rel    -= span;
						frames += c;
					end
				end
			end
			default: begin
				tbl_used   = 0;
				sum_frames = '0;
				sum_time   = '0;
			end
		endcase
		r.frames_total   = sum_frames;
		r.duration_total = sum_time;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t e;
		if (!arst_n) begin
			tbl_used   = 0;
			sum_frames = '0;
			sum_time   = '0;
			offset     = '0;
			fail_count = 0;
			awaited.delete();
		end else begin
			if (cfg_wen)
				offset = cfg_wdata;
			if (req_valid && req_ready)
				awaited.push_back(apply_request(req_word));
			if (rsp_valid && rsp_ready) begin
				if (awaited.size() == 0) begin
					report_mismatch("unexpected response", 0, 0);
				end else begin
					e = awaited.pop_front();
					if (rsp_word.status !== e.status)
						report_mismatch("status", rsp_word.status, e.status);
					if (rsp_word.answer_value !== e.answer_value)
						report_mismatch("answer_value", rsp_word.answer_value, e.answer_value);
					if (rsp_word.found_duration !== e.found_duration)
						report_mismatch("found_duration", rsp_word.found_duration,
							e.found_duration);
					if (rsp_word.frame_start !== e.frame_start)
						report_mismatch("frame_start", rsp_word.frame_start, e.frame_start);
					if (rsp_word.frames_total !== e.frames_total)
						report_mismatch("frames_total", rsp_word.frames_total, e.frames_total);
					if (rsp_word.duration_total !== e.duration_total)
						report_mismatch("duration_total", rsp_word.duration_total,
							e.duration_total);
				end
			end
		end
	end

endmodule

FILE: dv/tb_frame_duration_run_table.sv
// ----------------------------------------------------------------------------
// tb_frame_duration_run_table: stimulus and verdict for the run table
// Drives directed and random request words with random gaps and stalls,
// rewrites the time offset between phases and leaves all checking to the
// checker module.
// ----------------------------------------------------------------------------
module tb_frame_duration_run_table;
	import fdrt_pkg::*;

	localparam int LIMIT = 3_000_000;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	req_word_t          req_word;
	logic               rsp_valid;
	logic               rsp_ready;
	rsp_word_t          rsp_word;
	logic               cfg_wen;
	logic signed [47:0] cfg_wdata;
	int                 fail_count;
	int                 pending;
	int                 cycle_count;
	bit                 hold_long;

	frame_duration_run_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	fdrt_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_word   (req_word),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp_word   (rsp_word),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The watchdog ends a run that has hung; it is far beyond the slowest
	// legitimate run, where every lookup walks a full table.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Sends one word after a random gap, holding it steady until it is taken.
	// Valid drops only for a gap; with no gap the next word follows at once.
	task automatic send_word(logic [1:0] op, logic [31:0] dur, logic [47:0] q);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_word  <= '{operation: op, entry_duration: dur, query_value: q};
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Lets every outstanding word drain, then waits on for any work still in
	// flight, before the offset may change.
	task automatic drain;
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_offset(logic [47:0] value);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen   <= 1'b0;
	endtask

	function automatic logic [31:0] pick_duration(logic [31:0] prev);
		case ($urandom_range(0, 7))
			0, 1, 2: return prev;
			3:       return 32'd0;
			4:       return 32'hFFFF_FFFF;
			default: return $urandom_range(1, 3000);
		endcase
	endfunction

	function automatic logic [47:0] rand48;
		return {16'($urandom), 32'($urandom)};
	endfunction

	// The receiver stalls each word for a random number of cycles, apart from
	// one long hold-off that lets the block fill up and stall its input.
	initial begin
		int wait_cycles;
		bit long_done;
		rsp_ready = 1'b0;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_long && !long_done) begin
				rsp_ready <= 1'b0;
				repeat (400) @(negedge clk);
				long_done = 1'b1;
			end
			wait_cycles = $urandom_range(0, 1) ? 0 : $urandom_range(0, 13);
			if (wait_cycles != 0) begin
				rsp_ready <= 1'b0;
				repeat (wait_cycles - 1) @(negedge clk);
				@(negedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	initial begin
		logic [31:0] dur;
		logic [1:0]  op;
		logic [47:0] q;
		int          k;
		hold_long   = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req_word    = '0;
		cfg_wen     = 1'b0;
		cfg_wdata   = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: lookups in an empty table, both duration extremes,
		// a zero-duration run, negative and out-of-range queries, and clear.
		send_word(OP_F2T, 0, 48'd0);
		send_word(OP_T2F, 0, 48'd0);
		send_word(OP_APPEND, 32'd0, 48'd0);
		send_word(OP_APPEND, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_word(OP_APPEND, 32'hFFFF_FFFF, 48'd0);
		send_word(OP_APPEND, 32'd1000, 48'd0);
		send_word(OP_F2T, 0, 48'd0);
		send_word(OP_F2T, 0, 48'd2);
		send_word(OP_F2T, 0, 48'd3);
		send_word(OP_F2T, 0, 48'd4);
		send_word(OP_F2T, 0, 48'h8000_0000_0000);
		send_word(OP_F2T, 0, 48'h7FFF_FFFF_FFFF);
		send_word(OP_T2F, 0, 48'd5);
		send_word(OP_T2F, 0, 48'h1_FFFF_FFFE);
		send_word(OP_T2F, 0, 48'h1_FFFF_FFFF + 48'd500);
		send_word(OP_T2F, 0, 48'h7FFF_FFFF_FFFF);
		send_word(OP_T2F, 0, 48'h8000_0000_0000);
		send_word(OP_CLEAR, 0, 48'd0);
		drain();

		// Offset at the negative extreme; lookups then wrap into the top.
		write_offset(48'h8000_0000_0000);
		send_word(OP_APPEND, 32'd7, 48'd0);
		send_word(OP_T2F, 0, 48'h8000_0000_0003);
		send_word(OP_T2F, 0, 48'h7FFF_FFFF_FFFF);
		send_word(OP_F2T, 0, 48'd0);
		drain();

		// Offset at the positive extreme, so frame times wrap.
		write_offset(48'h7FFF_FFFF_FFFF);
		send_word(OP_F2T, 0, 48'd0);
		send_word(OP_T2F, 0, 48'h7FFF_FFFF_FFFF);
		send_word(OP_CLEAR, 0, 48'd0);
		drain();

		// Random phases, each with its own offset; one is a stretch of
		// appends that mostly open new runs, with a lookup now and then.
		dur = 32'd40;
		for (int phase = 0; phase < 6; phase++) begin
			write_offset(phase == 5 ? 48'd0 : rand48());
			if (phase == 2)
				hold_long = 1'b1;
			k = (phase == 4) ? 90 : 85;
			for (int n = 0; n < k; n++) begin
				if (phase == 4) begin
					// Alternating durations so that appends open new runs.
					dur = (dur == 32'd5) ? 32'd6 : 32'd5;
					op  = (n % 30 == 29) ? OP_F2T : OP_APPEND;
					q   = $urandom_range(0, 1100);
				end else begin
					case ($urandom_range(0, 19))
						0:                   op = OP_CLEAR;
						1, 2, 3, 4, 5, 6, 7: op = OP_APPEND;
						8, 9, 10, 11, 12:    op = OP_F2T;
						default:             op = OP_T2F;
					endcase
					dur = pick_duration(dur);
					case ($urandom_range(0, 5))
						0:       q = rand48();
						1, 2:    q = $urandom_range(0, 60);
						default: q = chk.offset + $urandom_range(0, 40000);
					endcase
				end
				send_word(op, $urandom_range(0, 3) == 0 ? 32'($urandom) : dur, q);
			end
			drain();
		end
		write_offset(48'd0);

		drain();
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
